// ===== hdl/page_counter_pattern_checker_macros.svh =====
// Assertion macros for the page counter pattern checker.
// Used by the queue and back-end modules; expects clk and rst in scope.
`ifndef PAGE_COUNTER_PATTERN_CHECKER_MACROS_SVH
`define PAGE_COUNTER_PATTERN_CHECKER_MACROS_SVH

`ifndef SYNTH
`define PCPC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pcpc assertion failed");
`define PCPC_ASSERT_IMPL(name, ante, cons) \
  `PCPC_ASSERT(name, (ante) |-> (cons))
`else
`define PCPC_ASSERT(name, prop)
`define PCPC_ASSERT_IMPL(name, ante, cons)
`endif

`endif

// ===== hdl/pcpc_pkg.sv =====
// Shared types and constants of the page counter pattern checker.
// No dependencies.
`default_nettype none

package pcpc_pkg;

  localparam int PAGE_WORDS   = 2048;
  localparam int CHECK_STRIDE = 8;
  localparam int PATTERN_DIV  = 8;
  localparam int PATTERN_SHIFT = $clog2(PATTERN_DIV);

  localparam int WORD_W    = 32;
  localparam int ERR_IDX_W = 11;
  localparam int POS_W     = $clog2(PAGE_WORDS);
  localparam int STRIDE_W  = (CHECK_STRIDE > 1) ? $clog2(CHECK_STRIDE) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WORD_W-1:0] BASE_STEP = WORD_W'(PAGE_WORDS / PATTERN_DIV);
  localparam logic [WORD_W-1:0] BASE_RESET = '1;

  localparam int ADDR_W = 3;
  localparam logic REG_CHECK_ENABLE  = 1'b0;
  localparam logic REG_RESYNC_ENABLE = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [POS_W-1:0]  pos_t;

  // One classified word on its way from front to back.
  typedef struct packed {
    word_t data;
    pos_t  pos;
    logic  first;
    logic  last;
    logic  check;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic check_enable;
    logic resync_enable;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/pcpc_front.sv =====
// Front end: accepts words and tags them with page position and check slot.
// Depends on pcpc_pkg.
`default_nettype none

module pcpc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pcpc_pkg::word_t    data_word,
  input  wire pcpc_pkg::q_status_t q_status,
  output logic                    push,
  output pcpc_pkg::entry_t        push_entry
);
  import pcpc_pkg::*;

  pos_t                pos;
  logic [STRIDE_W-1:0] stride;
  logic                last;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;
  assign last     = (pos == POS_W'(PAGE_WORDS - 1));

  always_comb begin
    push_entry.data  = data_word;
    push_entry.pos   = pos;
    push_entry.first = (pos == '0);
    push_entry.last  = last;
    push_entry.check = (stride == '0);
  end

  // stride restarts at every page so word 0 is always a check slot
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      stride <= '0;
    end else if (push) begin
      if (last) begin
        pos    <= '0;
        stride <= '0;
      end else begin
        pos <= pos + 1'b1;
        if (stride == STRIDE_W'(CHECK_STRIDE - 1)) begin
          stride <= '0;
        end else begin
          stride <= stride + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pcpc_queue.sv =====
// Short queue between front and back ends.
// Depends on pcpc_pkg and the assertion macros.
`default_nettype none
`include "page_counter_pattern_checker_macros.svh"

module pcpc_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire pcpc_pkg::entry_t    push_entry,
  input  wire logic                pop,
  output pcpc_pkg::entry_t         head,
  output pcpc_pkg::q_status_t      q_status
);
  import pcpc_pkg::*;

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head           = slots[rd_ptr];
  assign q_status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `PCPC_ASSERT(a_q_bound, count <= CNT_W'(QUEUE_DEPTH))
  `PCPC_ASSERT_IMPL(a_q_pop_nonempty, pop, count != '0)
  `PCPC_ASSERT(a_q_step, (count == $past(count)) || (count == $past(count) + 1'b1) || (count == $past(count) - 1'b1))

endmodule

`default_nettype wire

// ===== hdl/pcpc_back.sv =====
// Back end: compares check slots against the pattern, keeps page state,
// and holds the page verdict in an output register. Depends on pcpc_pkg.
`default_nettype none
`include "page_counter_pattern_checker_macros.svh"

module pcpc_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pcpc_pkg::cfg_t      cfg,
  input  wire pcpc_pkg::entry_t    head,
  input  wire pcpc_pkg::q_status_t q_status,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [31:0]              page_number,
  output logic                     page_checked,
  output logic                     page_error,
  output logic [10:0]              error_word_index,
  output logic [31:0]              expected_value,
  output logic [31:0]              actual_value,
  output logic [31:0]              error_total
);
  import pcpc_pkg::*;

  word_t                pattern_base;
  logic                 base_primed;
  word_t                first_word_of_page;
  logic                 page_check;
  logic                 page_failed;
  logic [ERR_IDX_W-1:0] fail_index;
  word_t                fail_expected;
  word_t                fail_actual;
  word_t                pages_done;
  word_t                failures_total;

  logic                 chk;
  logic                 prime;
  word_t                base_eff;
  word_t                expect_val;
  logic                 mismatch;
  logic                 failed_now;
  logic [ERR_IDX_W-1:0] idx_now;
  word_t                exp_now;
  word_t                act_now;
  word_t                total_next;
  word_t                base_next;

  // a verdict can only leave when the output register is free
  assign pop = !q_status.empty && (!head.last || !out_valid || !out_stall);

  always_comb begin
    chk        = head.first ? cfg.check_enable : page_check;
    prime      = head.first && cfg.check_enable && !base_primed;
    base_eff   = prime ? head.data : pattern_base;
    expect_val = base_eff + WORD_W'(head.pos >> PATTERN_SHIFT);
    mismatch   = chk && !page_failed && head.check && (head.data != expect_val);
    failed_now = page_failed || mismatch;
    idx_now    = mismatch ? ERR_IDX_W'(head.pos) : fail_index;
    exp_now    = mismatch ? expect_val : fail_expected;
    act_now    = mismatch ? head.data : fail_actual;
    total_next = (failed_now && (failures_total != '1)) ? failures_total + 1'b1
                                                        : failures_total;
    base_next  = ((failed_now && cfg.resync_enable) ? first_word_of_page : base_eff)
                 + BASE_STEP;
  end

  always_ff @(posedge clk) begin
    if (pop && head.first) begin
      first_word_of_page <= head.data;
    end
    if (pop && head.last) begin
      page_number      <= pages_done;
      page_checked     <= chk;
      page_error       <= failed_now;
      error_word_index <= idx_now;
      expected_value   <= exp_now;
      actual_value     <= act_now;
      error_total      <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_base   <= BASE_RESET;
      base_primed    <= 1'b0;
      page_check     <= 1'b0;
      page_failed    <= 1'b0;
      fail_index     <= '0;
      fail_expected  <= '0;
      fail_actual    <= '0;
      pages_done     <= '0;
      failures_total <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        if (head.first) begin
          page_check <= cfg.check_enable;
        end
        if (prime) begin
          base_primed <= 1'b1;
        end
        if (head.last) begin
          pattern_base   <= base_next;
          failures_total <= total_next;
          pages_done     <= pages_done + 1'b1;
          page_failed    <= 1'b0;
          fail_index     <= '0;
          fail_expected  <= '0;
          fail_actual    <= '0;
        end else begin
          pattern_base  <= base_eff;
          page_failed   <= failed_now;
          fail_index    <= idx_now;
          fail_expected <= exp_now;
          fail_actual   <= act_now;
        end
      end
      if (pop && head.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PCPC_ASSERT(a_total_mono, failures_total >= $past(failures_total))
  `PCPC_ASSERT_IMPL(a_unchecked_clean, out_valid && !page_checked, !page_error)
  `PCPC_ASSERT_IMPL(a_pass_zero, out_valid && !page_error, (error_word_index == '0) && (expected_value == '0) && (actual_value == '0))

endmodule

`default_nettype wire

// ===== hdl/page_counter_pattern_checker.sv =====
// Page counter pattern checker: top level with configuration registers.
// Depends on pcpc_pkg, pcpc_front, pcpc_queue and pcpc_back.
//
// Takes one 32-bit page word per cycle while in_stall is low, and checks every
// CHECK_STRIDE-th word of each PAGE_WORDS-word page against base + index/8.
// A word is written into a four-entry queue at the edge that accepts it and
// is compared by the back end (one 32-bit add and compare) when it reaches
// the queue head and is popped. A page's last word loads the verdict into the
// output register at the edge that pops it, which raises out_valid. The
// output register holds one verdict; while it is stalled the back end keeps
// draining ordinary words and halts only on the next page's last word, after
// which the queue fills and in_stall rises. Registers: check_enable at
// address 0 (reset 1), resync_enable at address 4 (reset 0); write them only
// while the block is idle. No clearing pass follows reset.
`default_nettype none

module page_counter_pattern_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] data_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      page_number,
  output logic             page_checked,
  output logic             page_error,
  output logic [10:0]      error_word_index,
  output logic [31:0]      expected_value,
  output logic [31:0]      actual_value,
  output logic [31:0]      error_total
);
  import pcpc_pkg::*;

  cfg_t      cfg;
  q_status_t q_status;
  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    head;
  logic      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_enable  <= 1'b1;
      cfg.resync_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_CHECK_ENABLE:  cfg.check_enable  <= pwdata[0];
        REG_RESYNC_ENABLE: cfg.resync_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CHECK_ENABLE:  prdata = {31'b0, cfg.check_enable};
      REG_RESYNC_ENABLE: prdata = {31'b0, cfg.resync_enable};
      default:           prdata = '0;
    endcase
  end

  pcpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_word  (data_word),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  pcpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  pcpc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .head             (head),
    .q_status         (q_status),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .page_number      (page_number),
    .page_checked     (page_checked),
    .page_error       (page_error),
    .error_word_index (error_word_index),
    .expected_value   (expected_value),
    .actual_value     (actual_value),
    .error_total      (error_total)
  );

endmodule

`default_nettype wire

// ===== tb/page_counter_pattern_checker_tb.sv =====
// Testbench for page_counter_pattern_checker: drives whole pages of words, mirrors the
// pattern check in a local predictor and compares every page verdict. Needs pcpc_pkg.
// Stimulus is a directed page table followed by random pages with random idling.
`timescale 1ns / 1ps

module page_counter_pattern_checker_tb;
  import pcpc_pkg::*;

  localparam int RANDOM_PAGES = 36;
  localparam int QUIET_FROM   = 30;      // no idling from this random page on
  localparam int PRESSURE_AT  = 4;
  localparam int HOLD_CYCLES  = 8000;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 8000000;

  localparam logic [2:0] ADDR_CHECK  = {REG_CHECK_ENABLE, 2'b00};
  localparam logic [2:0] ADDR_RESYNC = {REG_RESYNC_ENABLE, 2'b00};

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct packed {
    logic        chk;
    logic        rsy;
    logic        own;      // use base below instead of the running base
    word_t       base;
    logic        err_on;
    logic [10:0] err_at;
    logic        multi;    // corrupt every checked word from err_at on
    fill_t       fill;
    logic        known;
    logic        k_err;
    logic [10:0] k_idx;
  } page_row_t;

  typedef struct packed {
    logic [31:0] num;
    logic        chk;
    logic        err;
    logic [10:0] idx;
    logic [31:0] expv;
    logic [31:0] actv;
    logic [31:0] tot;
  } verdict_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] data_word;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] page_number;
  logic        page_checked;
  logic        page_error;
  logic [10:0] error_word_index;
  logic [31:0] expected_value;
  logic [31:0] actual_value;
  logic [31:0] error_total;

  page_counter_pattern_checker dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .data_word(data_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .page_number(page_number), .page_checked(page_checked), .page_error(page_error),
    .error_word_index(error_word_index), .expected_value(expected_value),
    .actual_value(actual_value), .error_total(error_total)
  );

  // register shadows
  logic cfg_chk;
  logic cfg_rsy;

  // predictor state
  int    cur_pos;
  word_t base_val;
  logic  primed;
  word_t page_first;
  logic  page_chk;
  logic  bad;
  int    bad_idx;
  word_t bad_exp;
  word_t bad_act;
  word_t page_count;
  word_t fail_count;

  // verdict fields typed in by the directed table for the page in flight
  logic        typed_on;
  logic        typed_chk;
  logic        typed_err;
  logic [10:0] typed_idx;

  verdict_t pending_q[$];
  int       mismatches;
  int       cycle_count;
  logic     idle_on;
  logic     hold_off;
  logic     pressure_go;
  int       stall_left;

  page_row_t dir_rows [13] = '{
    // chk rsy own base           err_on err_at multi fill         known k_err k_idx
    '{1'b0, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 11'd0,    1'b0, FILL_ONES,   1'b1, 1'b0, 11'd0},
    '{1'b1, 1'b0, 1'b1, 32'hFFFF_FFF0, 1'b0, 11'd0,    1'b0, FILL_RANDOM, 1'b1, 1'b0, 11'd0},
    '{1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 11'd0,    1'b0, FILL_ZERO,   1'b1, 1'b1, 11'd0},
    '{1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 11'd2040, 1'b0, FILL_RANDOM, 1'b1, 1'b1, 11'd2040},
    '{1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 11'd8,    1'b1, FILL_RANDOM, 1'b1, 1'b1, 11'd8},
    '{1'b1, 1'b1, 1'b1, 32'h1234_5678, 1'b0, 11'd0,    1'b0, FILL_RANDOM, 1'b1, 1'b1, 11'd0},
    '{1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 11'd0,    1'b0, FILL_RANDOM, 1'b1, 1'b0, 11'd0},
    '{1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b1, 11'd1000, 1'b0, FILL_ONES,   1'b1, 1'b1, 11'd1000},
    '{1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 11'd0,    1'b0, FILL_ONES,   1'b1, 1'b0, 11'd0},
    '{1'b0, 1'b1, 1'b0, 32'h0000_0000, 1'b1, 11'd0,    1'b1, FILL_ZERO,   1'b1, 1'b0, 11'd0},
    '{1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 11'd0,    1'b0, FILL_RANDOM, 1'b1, 1'b0, 11'd0},
    '{1'b1, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 11'd0,    1'b0, FILL_ZERO,   1'b1, 1'b1, 11'd0},
    '{1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 11'd0,    1'b0, FILL_RANDOM, 1'b1, 1'b0, 11'd0}
  };

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Predictor: one accepted word; queues a verdict on the last word of a page.
  function automatic void take_word(input word_t w);
    word_t    want;
    verdict_t v;
    if (cur_pos == 0) begin
      page_first = w;
      page_chk   = cfg_chk;
      if (page_chk && !primed) begin
        base_val = w;
        primed   = 1'b1;
      end
    end
    if (page_chk && !bad && (cur_pos % CHECK_STRIDE) == 0) begin
      want = base_val + word_t'(cur_pos / PATTERN_DIV);
      if (w != want) begin
        bad     = 1'b1;
        bad_idx = cur_pos;
        bad_exp = want;
        bad_act = w;
      end
    end
    if (cur_pos + 1 < PAGE_WORDS) begin
      cur_pos++;
    end else begin
      if (bad) begin
        if (fail_count != '1) fail_count++;
        if (cfg_rsy) base_val = page_first;
      end
      v.num  = page_count;
      v.chk  = page_chk;
      v.err  = bad;
      v.idx  = bad_idx[10:0];
      v.expv = bad_exp;
      v.actv = bad_act;
      v.tot  = fail_count;
      if (typed_on) begin
        v.chk    = typed_chk;
        v.err    = typed_err;
        v.idx    = typed_idx;
        typed_on = 1'b0;
      end
      pending_q.insert(pending_q.size(), v);
      base_val   = base_val + BASE_STEP;
      page_count = page_count + 1;
      cur_pos    = 0;
      bad        = 1'b0;
      bad_idx    = 0;
      bad_exp    = '0;
      bad_act    = '0;
    end
  endfunction

  task automatic check_verdict();
    verdict_t v;
    if (pending_q.size() == 0) begin
      report("unexpected page verdict", page_number, '0);
    end else begin
      v = pending_q.pop_front();
      if (page_number !== v.num) report("page_number", page_number, v.num);
      if (page_checked !== v.chk) report("page_checked", 32'(page_checked), 32'(v.chk));
      if (page_error !== v.err) report("page_error", 32'(page_error), 32'(v.err));
      if (error_word_index !== v.idx)
        report("error_word_index", 32'(error_word_index), 32'(v.idx));
      if (expected_value !== v.expv) report("expected_value", expected_value, v.expv);
      if (actual_value !== v.actv) report("actual_value", actual_value, v.actv);
      if (error_total !== v.tot) report("error_total", error_total, v.tot);
    end
  endtask

  // Result side: check accepted transactions, then pick the next stall value.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_verdict();
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 19) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Long hold-off on the result side so the block backs up into in_stall.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_word(input word_t w);
    int gap;
    if (idle_on && $urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_word(w);
  endtask

  task automatic send_page(input logic own, input word_t base, input logic err_on,
                           input logic [10:0] err_at, input logic multi, input fill_t fill);
    word_t start;
    word_t w;
    word_t flip;
    int    i;
    start = own ? base : base_val;
    for (i = 0; i < PAGE_WORDS; i++) begin
      case (fill)
        FILL_ZERO: w = '0;
        FILL_ONES: w = '1;
        default:   w = $urandom;
      endcase
      if (i % CHECK_STRIDE == 0) begin
        w = start + word_t'(i / PATTERN_DIV);
        if (err_on && (i == err_at || (multi && i > err_at))) begin
          do flip = $urandom; while (flip == '0);
          w = w ^ flip;
        end
      end
      send_word(w);
    end
  endtask

  // Let the block go quiet before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_config(input logic chk, input logic rsy, input bit every);
    if (every || chk != cfg_chk || rsy != cfg_rsy) begin
      settle();
      if (every || chk != cfg_chk) begin
        reg_write(ADDR_CHECK, 32'(chk));
        cfg_chk = chk;
      end
      if (every || rsy != cfg_rsy) begin
        reg_write(ADDR_RESYNC, 32'(rsy));
        cfg_rsy = rsy;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  initial begin
    page_row_t   row;
    int          pg;
    int          mode;
    logic        own;
    word_t       base;
    logic        err_on;
    logic [10:0] err_at;
    logic        multi;
    fill_t       fill;

    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    data_word = '0;
    out_stall = 1'b0;
    hold_off = 1'b0;
    pressure_go = 1'b0;
    idle_on = 1'b1;
    stall_left = 0;
    mismatches = 0;
    cycle_count = 0;
    typed_on = 1'b0;
    typed_chk = 1'b0;
    typed_err = 1'b0;
    typed_idx = '0;

    cfg_chk = 1'b1;
    cfg_rsy = 1'b0;
    cur_pos = 0;
    base_val = BASE_RESET;
    primed = 1'b0;
    page_first = '0;
    page_chk = 1'b0;
    bad = 1'b0;
    bad_idx = 0;
    bad_exp = '0;
    bad_act = '0;
    page_count = '0;
    fail_count = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(1'b1, 1'b0, 1'b1);

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      set_config(row.chk, row.rsy, 1'b0);
      typed_on  = row.known;
      typed_chk = row.chk;
      typed_err = row.k_err;
      typed_idx = row.k_idx;
      send_page(row.own, row.base, row.err_on, row.err_at, row.multi, row.fill);
    end

    for (pg = 0; pg < RANDOM_PAGES; pg++) begin
      idle_on = !(pg >= QUIET_FROM || (pg >= 12 && pg < 16));
      if (pg == PRESSURE_AT) pressure_go = 1'b1;
      if ($urandom_range(0, 3) == 0)
        set_config($urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)), 1'b0);
      own    = 1'b0;
      base   = $urandom;
      err_on = 1'b0;
      err_at = 11'($urandom_range(0, PAGE_WORDS / CHECK_STRIDE - 1) * CHECK_STRIDE);
      multi  = 1'b0;
      fill   = FILL_RANDOM;
      mode   = $urandom_range(0, 9);
      case (mode)
        5, 6: err_on = 1'b1;
        7: begin
          err_on = 1'b1;
          multi  = 1'b1;
        end
        8: begin
          // noise page: every checked word corrupted
          err_on = 1'b1;
          multi  = 1'b1;
          err_at = '0;
        end
        9: own = 1'b1;
        default: ;
      endcase
      send_page(own, base, err_on, err_at, multi, fill);
    end

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
